>>> src/topic_subscription_table_unit_defines.svh
`ifndef TOPIC_SUBSCRIPTION_TABLE_UNIT_DEFINES_SVH
`define TOPIC_SUBSCRIPTION_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TST_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define TST_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define TST_ASSERT(lbl, clk, rst_n, prop)
`define TST_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

>>> src/tst_pkg.sv
package tst_pkg;

    localparam int TOPIC_SLOTS    = 16;
    localparam int SUBS_PER_TOPIC = 16;

    localparam int TIDX_W   = (TOPIC_SLOTS > 1) ? $clog2(TOPIC_SLOTS) : 1;
    localparam int SIDX_W   = (SUBS_PER_TOPIC > 1) ? $clog2(SUBS_PER_TOPIC) : 1;
    localparam int SCNT_W   = $clog2(SUBS_PER_TOPIC + 1);
    localparam int SADDR_W  = TIDX_W + SIDX_W;
    localparam int SUB_DEPTH = 1 << SADDR_W;

    localparam int KEY_W    = 64;
    localparam int ADDR_W   = 32;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DELIM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WILD  = 1'd1;

    localparam logic [CHAR_W-1:0] DELIM_RESET = 8'd33;
    localparam logic [CHAR_W-1:0] WILD_RESET  = 8'd35;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP         = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_TOPIC    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SUB      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOPIC_DELIM = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOPIC_WILD  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_CONT_DELIM  = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NONE        = 3'd7;

    localparam logic OP_SUBSCRIBE = 1'b0;
    localparam logic OP_PUBLISH   = 1'b1;

    typedef struct packed {
        logic              claim;
        logic [TIDX_W-1:0] idx;
        logic [KEY_W-1:0]  key;
    } tbl_req_t;

    typedef struct packed {
        logic hit;
        logic free;
    } tbl_rsp_t;

    typedef struct packed {
        logic               rd_en;
        logic [SADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [SADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0]  wr_data;
        logic               clr_row;
        logic [TIDX_W-1:0]  clr_slot;
    } sub_req_t;

    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic             stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (k[8*i +: 8] == 8'd0)
                stop = 1'b1;
            if (!stop)
                r[8*i +: 8] = k[8*i +: 8];
        end
        return r;
    endfunction

    function automatic logic key_has(input logic [KEY_W-1:0] k, input logic [CHAR_W-1:0] c);
        logic hit;
        logic stop;
        hit  = (c == 8'd0);
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (k[8*i +: 8] == 8'd0)
                stop = 1'b1;
            else if (!stop && (k[8*i +: 8] == c))
                hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

>>> src/topic_subscription_table_unit.sv
// Publish/subscribe routing table for up to TOPIC_SLOTS topics of 8-byte keys, each
// with SUBS_PER_TOPIC subscriber addresses. One transaction is worked at a time.
// A single key comparator walks the topic slots one per cycle, and a single read
// port on the subscriber memory walks the slots of the topic one per cycle, though
// a publish holds that walk while a forward waits on out_stall. A topic that is
// neither found nor claimed ends after the topic walk, and a rejected topic or
// contents flag finishes without either walk. A publish that fans out waits on
// out_stall for each forward, so a stalled output stretches the transaction.
// The last result may still wait on the output while the next transaction is taken.
`include "topic_subscription_table_unit_defines.svh"

module topic_subscription_table_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [tst_pkg::KEY_W-1:0]     topic_key,
    input  logic [tst_pkg::ADDR_W-1:0]    subscriber_ip,
    input  logic                          contents_has_delim,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          kind,
    output logic [tst_pkg::ADDR_W-1:0]    forward_ip,
    output logic [tst_pkg::STATUS_W-1:0]  status,
    output logic                          last,
    input  logic                          cfg_we,
    input  logic [tst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tst_pkg::CHAR_W-1:0]    cfg_data
);
    import tst_pkg::*;

    tbl_req_t          tbl_req;
    tbl_rsp_t          tbl_rsp;
    sub_req_t          sub_req;
    logic [ADDR_W-1:0] sub_rd_data;

    tst_ctrl u_ctrl (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .op                 (op),
        .topic_key          (topic_key),
        .subscriber_ip      (subscriber_ip),
        .contents_has_delim (contents_has_delim),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .kind               (kind),
        .forward_ip         (forward_ip),
        .status             (status),
        .last               (last),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .tbl_req            (tbl_req),
        .tbl_rsp            (tbl_rsp),
        .sub_req            (sub_req),
        .sub_rd_data        (sub_rd_data)
    );

    tst_topic_table u_topic_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req),
        .rsp   (tbl_rsp)
    );

    tst_sub_store u_sub_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (sub_req),
        .rd_data (sub_rd_data)
    );

    `TST_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall)
    `TST_ASSERT(a_status_is_final, clk, rst_n, out_valid && !kind |-> last && forward_ip == '0)
    `TST_NEVER(a_claim_and_write, clk, rst_n, tbl_req.claim && sub_req.wr_en)
    `TST_NEVER(a_read_and_write, clk, rst_n, sub_req.rd_en && sub_req.wr_en)

endmodule

>>> src/tst_topic_table.sv
module tst_topic_table (
    input  logic              clk,
    input  logic              rst_n,
    input  tst_pkg::tbl_req_t req,
    output tst_pkg::tbl_rsp_t rsp
);
    import tst_pkg::*;

    logic [KEY_W-1:0]       keys_reg [TOPIC_SLOTS];
    logic [TOPIC_SLOTS-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.claim)
            keys_reg[req.idx] <= req.key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.claim)
        begin
            valid_reg[req.idx] <= 1'b1;
        end
    end

    always_comb
    begin
        rsp.free = !valid_reg[req.idx];
        rsp.hit  = valid_reg[req.idx] && (keys_reg[req.idx] == req.key);
    end

endmodule

>>> src/tst_sub_store.sv
module tst_sub_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tst_pkg::sub_req_t          req,
    output logic [tst_pkg::ADDR_W-1:0] rd_data
);
    import tst_pkg::*;

    logic [ADDR_W-1:0]    mem [SUB_DEPTH];
    logic [ADDR_W-1:0]    rd_data_reg;
    logic [SUB_DEPTH-1:0] vld_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.wr_addr] <= req.wr_data;
        if (req.rd_en)
            rd_data_reg <= mem[req.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.clr_row)
            begin
                for (int s = 0; s < SUBS_PER_TOPIC; s++)
                    vld_reg[{req.clr_slot, SIDX_W'(s)}] <= 1'b0;
            end
            if (req.wr_en)
                vld_reg[req.wr_addr] <= 1'b1;
            if (req.rd_en)
                rd_vld_reg <= vld_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

>>> src/tst_ctrl.sv
module tst_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic [tst_pkg::KEY_W-1:0]    topic_key,
    input  logic [tst_pkg::ADDR_W-1:0]   subscriber_ip,
    input  logic                         contents_has_delim,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         kind,
    output logic [tst_pkg::ADDR_W-1:0]   forward_ip,
    output logic [tst_pkg::STATUS_W-1:0] status,
    output logic                         last,
    input  logic                         cfg_we,
    input  logic [tst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tst_pkg::CHAR_W-1:0]   cfg_data,
    output tst_pkg::tbl_req_t            tbl_req,
    input  tst_pkg::tbl_rsp_t            tbl_rsp,
    output tst_pkg::sub_req_t            sub_req,
    input  logic [tst_pkg::ADDR_W-1:0]   sub_rd_data
);
    import tst_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_TSCAN = 3'd2;
    localparam logic [2:0] S_TEND  = 3'd3;
    localparam logic [2:0] S_SSCAN = 3'd4;
    localparam logic [2:0] S_SEND  = 3'd5;
    localparam logic [2:0] S_STAT  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic                op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                cdelim_reg, cdelim_next;
    logic [CHAR_W-1:0]   delim_reg, delim_next;
    logic [CHAR_W-1:0]   wild_reg, wild_next;
    logic [TIDX_W-1:0]   t_cnt_reg, t_cnt_next;
    logic                found_reg, found_next;
    logic [TIDX_W-1:0]   slot_reg, slot_next;
    logic                free_vld_reg, free_vld_next;
    logic [TIDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [SCNT_W-1:0]   s_iss_reg, s_iss_next;
    logic [SIDX_W-1:0]   s_chk_reg, s_chk_next;
    logic                chk_vld_reg, chk_vld_next;
    logic                dup_reg, dup_next;
    logic                emp_vld_reg, emp_vld_next;
    logic [SIDX_W-1:0]   emp_idx_reg, emp_idx_next;
    logic                pend_vld_reg, pend_vld_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [STATUS_W-1:0] st_code_reg, st_code_next;
    logic                out_valid_reg, out_valid_next;
    logic                kind_reg, kind_next;
    logic [ADDR_W-1:0]   dest_reg, dest_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                last_reg, last_next;

    logic out_free;
    logic emit;
    logic proceed;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        addr_next      = addr_reg;
        cdelim_next    = cdelim_reg;
        delim_next     = delim_reg;
        wild_next      = wild_reg;
        t_cnt_next     = t_cnt_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        free_vld_next  = free_vld_reg;
        free_idx_next  = free_idx_reg;
        s_iss_next     = s_iss_reg;
        s_chk_next     = s_chk_reg;
        chk_vld_next   = chk_vld_reg;
        dup_next       = dup_reg;
        emp_vld_next   = emp_vld_reg;
        emp_idx_next   = emp_idx_reg;
        pend_vld_next  = pend_vld_reg;
        pend_addr_next = pend_addr_reg;
        st_code_next   = st_code_reg;
        kind_next      = kind_reg;
        dest_next      = dest_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        emit           = 1'b0;
        proceed        = 1'b0;

        tbl_req.claim  = 1'b0;
        tbl_req.idx    = t_cnt_reg;
        tbl_req.key    = key_reg;

        sub_req.rd_en    = 1'b0;
        sub_req.rd_addr  = {slot_reg, s_iss_reg[SIDX_W-1:0]};
        sub_req.wr_en    = 1'b0;
        sub_req.wr_addr  = {slot_reg, emp_idx_reg};
        sub_req.wr_data  = addr_reg;
        sub_req.clr_row  = 1'b0;
        sub_req.clr_slot = free_idx_reg;

        if (cfg_we)
        begin
            if (cfg_index == REG_DELIM)
                delim_next = cfg_data;
            else
                wild_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op;
                    key_next    = norm_key(topic_key);
                    addr_next   = subscriber_ip;
                    cdelim_next = contents_has_delim;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                t_cnt_next    = '0;
                found_next    = 1'b0;
                free_vld_next = 1'b0;
                if (key_has(key_reg, delim_reg))
                begin
                    st_code_next = ST_TOPIC_DELIM;
                    state_next   = S_STAT;
                end
                else if (op_reg == OP_PUBLISH && key_has(key_reg, wild_reg))
                begin
                    st_code_next = ST_TOPIC_WILD;
                    state_next   = S_STAT;
                end
                else if (op_reg == OP_PUBLISH && cdelim_reg)
                begin
                    st_code_next = ST_CONT_DELIM;
                    state_next   = S_STAT;
                end
                else
                begin
                    state_next = S_TSCAN;
                end
            end
            S_TSCAN:
            begin
                if (tbl_rsp.hit && !found_reg)
                begin
                    found_next = 1'b1;
                    slot_next  = t_cnt_reg;
                end
                if (tbl_rsp.free && !free_vld_reg)
                begin
                    free_vld_next = 1'b1;
                    free_idx_next = t_cnt_reg;
                end
                if (t_cnt_reg == TIDX_W'(TOPIC_SLOTS - 1))
                    state_next = S_TEND;
                else
                    t_cnt_next = t_cnt_reg + 1'b1;
            end
            S_TEND:
            begin
                s_iss_next    = '0;
                chk_vld_next  = 1'b0;
                dup_next      = 1'b0;
                emp_vld_next  = 1'b0;
                pend_vld_next = 1'b0;
                if (found_reg)
                begin
                    state_next = S_SSCAN;
                end
                else if (op_reg == OP_SUBSCRIBE && free_vld_reg)
                begin
                    tbl_req.claim   = 1'b1;
                    tbl_req.idx     = free_idx_reg;
                    sub_req.clr_row = 1'b1;
                    slot_next       = free_idx_reg;
                    state_next      = S_SSCAN;
                end
                else
                begin
                    st_code_next = (op_reg == OP_SUBSCRIBE) ? ST_NO_TOPIC : ST_NONE;
                    state_next   = S_STAT;
                end
            end
            S_SSCAN:
            begin
                proceed = !(chk_vld_reg && op_reg == OP_PUBLISH && sub_rd_data != '0
                            && pend_vld_reg && !out_free);
                if (proceed)
                begin
                    if (chk_vld_reg)
                    begin
                        if (op_reg == OP_SUBSCRIBE)
                        begin
                            if (sub_rd_data == addr_reg)
                                dup_next = 1'b1;
                            if (sub_rd_data == '0 && !emp_vld_reg)
                            begin
                                emp_vld_next = 1'b1;
                                emp_idx_next = s_chk_reg;
                            end
                        end
                        else if (sub_rd_data != '0)
                        begin
                            if (pend_vld_reg)
                            begin
                                emit        = 1'b1;
                                kind_next   = 1'b1;
                                dest_next   = pend_addr_reg;
                                status_next = ST_OK;
                                last_next   = 1'b0;
                            end
                            pend_vld_next  = 1'b1;
                            pend_addr_next = sub_rd_data;
                        end
                    end
                    if (s_iss_reg < SCNT_W'(SUBS_PER_TOPIC))
                    begin
                        sub_req.rd_en = 1'b1;
                        s_iss_next    = s_iss_reg + 1'b1;
                        s_chk_next    = s_iss_reg[SIDX_W-1:0];
                        chk_vld_next  = 1'b1;
                    end
                    else
                    begin
                        chk_vld_next = 1'b0;
                        state_next   = S_SEND;
                    end
                end
            end
            S_SEND:
            begin
                if (op_reg == OP_SUBSCRIBE)
                begin
                    if (dup_reg)
                    begin
                        st_code_next = ST_DUP;
                    end
                    else if (emp_vld_reg)
                    begin
                        sub_req.wr_en = 1'b1;
                        st_code_next  = ST_OK;
                    end
                    else
                    begin
                        st_code_next = ST_NO_SUB;
                    end
                    state_next = S_STAT;
                end
                else if (!pend_vld_reg)
                begin
                    st_code_next = ST_NONE;
                    state_next   = S_STAT;
                end
                else if (out_free)
                begin
                    emit        = 1'b1;
                    kind_next   = 1'b1;
                    dest_next   = pend_addr_reg;
                    status_next = ST_OK;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_STAT:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    kind_next   = 1'b0;
                    dest_next   = '0;
                    status_next = st_code_reg;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        if (!emit)
        begin
            kind_next   = kind_reg;
            dest_next   = dest_reg;
            status_next = status_reg;
            last_next   = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            delim_reg     <= DELIM_RESET;
            wild_reg      <= WILD_RESET;
            out_valid_reg <= 1'b0;
            chk_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            free_vld_reg  <= 1'b0;
            dup_reg       <= 1'b0;
            emp_vld_reg   <= 1'b0;
            pend_vld_reg  <= 1'b0;
            t_cnt_reg     <= '0;
            s_iss_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            delim_reg     <= delim_next;
            wild_reg      <= wild_next;
            out_valid_reg <= out_valid_next;
            chk_vld_reg   <= chk_vld_next;
            found_reg     <= found_next;
            free_vld_reg  <= free_vld_next;
            dup_reg       <= dup_next;
            emp_vld_reg   <= emp_vld_next;
            pend_vld_reg  <= pend_vld_next;
            t_cnt_reg     <= t_cnt_next;
            s_iss_reg     <= s_iss_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        addr_reg      <= addr_next;
        cdelim_reg    <= cdelim_next;
        slot_reg      <= slot_next;
        free_idx_reg  <= free_idx_next;
        s_chk_reg     <= s_chk_next;
        emp_idx_reg   <= emp_idx_next;
        pend_addr_reg <= pend_addr_next;
        st_code_reg   <= st_code_next;
        kind_reg      <= kind_next;
        dest_reg      <= dest_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign forward_ip = dest_reg;
    assign status     = status_reg;
    assign last       = last_reg;

endmodule
